@@ rtl/icte_pkg.sv @@
// Shared types and constants of the IRC color text encoder.
// Holds the cell command format, byte codes and the color palette; no dependencies.
package icte_pkg;

	// Byte slots of one cell, in the order they leave the block
	localparam int NUM_PH      = 13;
	localparam int PH_OPEN     = 0;
	localparam int PH_CODE     = 1;
	localparam int PH_FG_TENS  = 2;
	localparam int PH_FG_ONES  = 3;
	localparam int PH_COMMA    = 4;
	localparam int PH_BG_TENS  = 5;
	localparam int PH_BG_ONES  = 6;
	localparam int PH_STX1     = 7;
	localparam int PH_STX2     = 8;
	localparam int PH_CHAR     = 9;
	localparam int PH_CR       = 10;
	localparam int PH_LF       = 11;
	localparam int PH_CLOSE    = 12;

	typedef logic [NUM_PH-1:0] ph_mask_t;
	typedef logic [3:0]        ph_idx_t;

	typedef struct packed {
		ph_mask_t   mask;
		logic [3:0] fg;
		logic [3:0] bg;
		logic [6:0] ch;
	} cell_cmd_t;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	localparam logic [7:0] BYTE_RESET = 8'h0f;
	localparam logic [7:0] BYTE_COLOR = 8'h03;
	localparam logic [7:0] BYTE_COMMA = 8'h2c;
	localparam logic [7:0] BYTE_BOLD  = 8'h02;
	localparam logic [7:0] BYTE_CR    = 8'h0d;
	localparam logic [7:0] BYTE_LF    = 8'h0a;
	localparam logic [7:0] BYTE_DIG0  = 8'h30;

	localparam logic [20:0] CHAR_SPACE = 21'h20;
	localparam logic [20:0] CHAR_ZERO  = 21'h30;
	localparam logic [20:0] CHAR_NINE  = 21'h39;

	localparam logic [4:0] NO_COLOR = 5'd31;

	localparam logic CFG_WIDTH_IDX  = 1'b0;
	localparam logic CFG_HEIGHT_IDX = 1'b1;

	// ANSI index to IRC color number
	function automatic logic [3:0] palette(input logic [3:0] idx);
		logic [3:0] r;
		case (idx)
			4'd0:    r = 4'd1;
			4'd1:    r = 4'd2;
			4'd2:    r = 4'd3;
			4'd3:    r = 4'd10;
			4'd4:    r = 4'd5;
			4'd5:    r = 4'd6;
			4'd6:    r = 4'd7;
			4'd7:    r = 4'd15;
			4'd8:    r = 4'd14;
			4'd9:    r = 4'd12;
			4'd10:   r = 4'd9;
			4'd11:   r = 4'd11;
			4'd12:   r = 4'd4;
			4'd13:   r = 4'd13;
			4'd14:   r = 4'd8;
			default: r = 4'd0;
		endcase
		return r;
	endfunction

endpackage

@@ rtl/icte_front.sv @@
// Front end: canvas registers, cell position and color history, cell classification.
// Depends on icte_pkg; produces one cell command per accepted cell.
module icte_front #(
	parameter int MAX_DIM = 4096
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	input  logic                 cfg_index,
	input  logic [12:0]          cfg_data,
	input  logic                 cell_valid,
	input  logic [3:0]           cell_fg,
	input  logic [3:0]           cell_bg,
	input  logic [20:0]          cell_char,
	input  logic                 queue_full,
	output logic                 push,
	output icte_pkg::cell_cmd_t  cmd
);

	localparam int CW = $clog2(MAX_DIM);
	localparam int DW = (CW + 1 > 13) ? CW + 1 : 13;

	function automatic logic [DW-1:0] clamp_dim(input logic [12:0] v);
		logic [DW-1:0] e;
		e = DW'(v);
		if (e == '0)
			return DW'(1);
		if (e > DW'(MAX_DIM))
			return DW'(MAX_DIM);
		return e;
	endfunction

	logic [DW-1:0] width_q, height_q;
	logic [CW-1:0] column_q, row_q;
	logic [4:0]    prev_fg_q, prev_bg_q;

	logic [3:0]    fgm, bgm;
	logic          fg_diff, bg_diff, is_space, is_digit;
	logic          code, fg_en, keep_fg, open, eol, close;
	logic [CW:0]   col_inc, row_inc;

	always_comb begin
		fgm      = icte_pkg::palette(cell_fg);
		bgm      = icte_pkg::palette(cell_bg);
		fg_diff  = {1'b0, fgm} != prev_fg_q;
		bg_diff  = {1'b0, bgm} != prev_bg_q;
		is_space = cell_char == icte_pkg::CHAR_SPACE;
		is_digit = cell_char inside {[icte_pkg::CHAR_ZERO:icte_pkg::CHAR_NINE]};
		// a space under the same background keeps the old foreground
		keep_fg  = !bg_diff && fg_diff && is_space;
		code     = bg_diff || (fg_diff && !is_space);
		fg_en    = fg_diff && code;
		open     = (column_q == '0) && (row_q == '0);
		col_inc  = {1'b0, column_q} + 1'b1;
		row_inc  = {1'b0, row_q} + 1'b1;
		eol      = DW'(col_inc) >= width_q;
		close    = eol && (DW'(row_inc) >= height_q);

		cmd.mask                         = '0;
		cmd.mask[icte_pkg::PH_OPEN]      = open;
		cmd.mask[icte_pkg::PH_CODE]      = code;
		cmd.mask[icte_pkg::PH_FG_TENS]   = fg_en && (fgm >= 4'd10);
		cmd.mask[icte_pkg::PH_FG_ONES]   = fg_en;
		cmd.mask[icte_pkg::PH_COMMA]     = bg_diff;
		cmd.mask[icte_pkg::PH_BG_TENS]   = bg_diff && (bgm >= 4'd10);
		cmd.mask[icte_pkg::PH_BG_ONES]   = bg_diff;
		cmd.mask[icte_pkg::PH_STX1]      = code && is_digit;
		cmd.mask[icte_pkg::PH_STX2]      = code && is_digit;
		cmd.mask[icte_pkg::PH_CHAR]      = 1'b1;
		cmd.mask[icte_pkg::PH_CR]        = eol;
		cmd.mask[icte_pkg::PH_LF]        = eol;
		cmd.mask[icte_pkg::PH_CLOSE]     = close;
		cmd.fg = fgm;
		cmd.bg = bgm;
		cmd.ch = cell_char[6:0];
	end

	assign push = cell_valid && !queue_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q   <= clamp_dim(13'd80);
			height_q  <= clamp_dim(13'd32);
			column_q  <= '0;
			row_q     <= '0;
			prev_fg_q <= icte_pkg::NO_COLOR;
			prev_bg_q <= icte_pkg::NO_COLOR;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					icte_pkg::CFG_WIDTH_IDX:  width_q  <= clamp_dim(cfg_data);
					icte_pkg::CFG_HEIGHT_IDX: height_q <= clamp_dim(cfg_data);
					default: ;
				endcase
			end
			if (push) begin
				if (eol) begin
					// forget colors at each row start
					column_q  <= '0;
					prev_fg_q <= icte_pkg::NO_COLOR;
					prev_bg_q <= icte_pkg::NO_COLOR;
					row_q     <= close ? '0 : row_inc[CW-1:0];
				end else begin
					column_q  <= col_inc[CW-1:0];
					prev_fg_q <= keep_fg ? prev_fg_q : {1'b0, fgm};
					prev_bg_q <= {1'b0, bgm};
				end
			end
		end
	end

endmodule

@@ rtl/icte_queue.sv @@
// Small first-in first-out queue of cell commands between front and back end.
// Depends on icte_pkg for the command type and depth.
module icte_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  icte_pkg::cell_cmd_t  push_cmd,
	input  logic                 pop,
	output logic                 full,
	output logic                 empty,
	output icte_pkg::cell_cmd_t  head_cmd
);

	icte_pkg::cell_cmd_t           mem_q [icte_pkg::QUEUE_DEPTH];
	logic [icte_pkg::QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [icte_pkg::QPTR_W:0]     count_q;

	function automatic logic [icte_pkg::QPTR_W-1:0] next_ptr(
		input logic [icte_pkg::QPTR_W-1:0] p);
		if (p == icte_pkg::QPTR_W'(icte_pkg::QUEUE_DEPTH - 1))
			return '0;
		return p + 1'b1;
	endfunction

	assign full     = count_q == (icte_pkg::QPTR_W + 1)'(icte_pkg::QUEUE_DEPTH);
	assign empty    = count_q == '0;
	assign head_cmd = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= next_ptr(wr_ptr_q);
			if (pop)
				rd_ptr_q <= next_ptr(rd_ptr_q);
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: ;
			endcase
		end
	end

endmodule

@@ rtl/icte_back.sv @@
// Back end: walks the byte slots of the head cell command, one byte per cycle while the output is not stalled.
// Depends on icte_pkg; drives the registered output stream.
module icte_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 empty,
	input  icte_pkg::cell_cmd_t  cmd,
	output logic                 pop,
	output logic                 out_tvalid,
	input  logic                 out_tready,
	output logic [7:0]           out_tdata,
	output logic                 out_tlast
);

	icte_pkg::ph_mask_t done_q, pend, sel;
	icte_pkg::ph_idx_t  idx;
	logic               last, advance;
	logic [7:0]         byte_val;
	logic               out_tvalid_q, out_tlast_q;
	logic [7:0]         out_tdata_q;

	function automatic logic [7:0] ones_digit(input logic [3:0] n);
		return icte_pkg::BYTE_DIG0 + 8'((n >= 4'd10) ? n - 4'd10 : n);
	endfunction

	always_comb begin
		pend = cmd.mask & ~done_q;
		sel  = pend & (~pend + 1'b1);
		last = (pend & ~sel) == '0;
		idx  = '0;
		for (int i = 0; i < icte_pkg::NUM_PH; i++) begin
			if (sel[i])
				idx = icte_pkg::ph_idx_t'(i);
		end
		case (idx)
			icte_pkg::ph_idx_t'(icte_pkg::PH_OPEN):    byte_val = icte_pkg::BYTE_RESET;
			icte_pkg::ph_idx_t'(icte_pkg::PH_CODE):    byte_val = icte_pkg::BYTE_COLOR;
			icte_pkg::ph_idx_t'(icte_pkg::PH_FG_TENS): byte_val = icte_pkg::BYTE_DIG0 + 8'd1;
			icte_pkg::ph_idx_t'(icte_pkg::PH_FG_ONES): byte_val = ones_digit(cmd.fg);
			icte_pkg::ph_idx_t'(icte_pkg::PH_COMMA):   byte_val = icte_pkg::BYTE_COMMA;
			icte_pkg::ph_idx_t'(icte_pkg::PH_BG_TENS): byte_val = icte_pkg::BYTE_DIG0 + 8'd1;
			icte_pkg::ph_idx_t'(icte_pkg::PH_BG_ONES): byte_val = ones_digit(cmd.bg);
			icte_pkg::ph_idx_t'(icte_pkg::PH_STX1),
			icte_pkg::ph_idx_t'(icte_pkg::PH_STX2):    byte_val = icte_pkg::BYTE_BOLD;
			icte_pkg::ph_idx_t'(icte_pkg::PH_CHAR):    byte_val = {1'b0, cmd.ch};
			icte_pkg::ph_idx_t'(icte_pkg::PH_CR):      byte_val = icte_pkg::BYTE_CR;
			icte_pkg::ph_idx_t'(icte_pkg::PH_LF):      byte_val = icte_pkg::BYTE_LF;
			icte_pkg::ph_idx_t'(icte_pkg::PH_CLOSE):   byte_val = icte_pkg::BYTE_RESET;
			default:                                   byte_val = icte_pkg::BYTE_RESET;
		endcase
	end

	// refill the output register whenever a cell command is queued and the register is empty or being taken
	assign advance    = !empty && (!out_tvalid_q || out_tready);
	assign pop        = advance && last;
	assign out_tvalid = out_tvalid_q;
	assign out_tdata  = out_tdata_q;
	assign out_tlast  = out_tlast_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q       <= '0;
			out_tvalid_q <= 1'b0;
		end else begin
			if (advance)
				done_q <= last ? '0 : (done_q | sel);
			if (advance)
				out_tvalid_q <= 1'b1;
			else if (out_tready)
				out_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_tdata_q <= byte_val;
			out_tlast_q <= last;
		end
	end

endmodule

@@ rtl/irc_color_text_encoder.sv @@
// Top level of the IRC color text encoder: front end, command queue, back end.
// Depends on icte_pkg, icte_front, icte_queue and icte_back.
//
//  channel  | dir | payload
//  ---------+-----+---------------------------------------------------
//  cfg      | in  | cfg_index (0 width, 1 height), cfg_data 13 bits
//  in  (s)  | in  | tdata: fg_color, bg_color, char_code
//  out (m)  | out | tdata: out_byte; tlast: last_byte
//
// The back end sends one byte per cycle while the output is not stalled, and a cell
// is 1 to 13 bytes there; the byte count of the cell sets the rate.
// The front end takes one cell per cycle while the 4-entry command queue has room.
// Reset clears position, color history, queue and output valid; the canvas
// registers return to 80 by 32. No clearing pass is needed.
// A stalled output holds its byte; cells keep entering until the queue fills.
module irc_color_text_encoder #(
	parameter int MAX_DIM = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [12:0] cfg_data,
	input  logic        in_tvalid,
	output logic        in_tready,
	input  logic [31:0] in_tdata,   // [3:0] fg_color, [7:4] bg_color, [28:8] char_code
	output logic        out_tvalid,
	input  logic        out_tready,
	output logic [7:0]  out_tdata,  // [7:0] out_byte
	output logic        out_tlast   // last_byte
);

	icte_pkg::cell_cmd_t push_cmd, head_cmd;
	logic                push, pop, full, empty;

	assign cfg_ready = 1'b1;
	assign in_tready = !full;

	icte_front #(
		.MAX_DIM (MAX_DIM)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.cell_valid (in_tvalid),
		.cell_fg    (in_tdata[3:0]),
		.cell_bg    (in_tdata[7:4]),
		.cell_char  (in_tdata[28:8]),
		.queue_full (full),
		.push       (push),
		.cmd        (push_cmd)
	);

	icte_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.full     (full),
		.empty    (empty),
		.head_cmd (head_cmd)
	);

	icte_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.empty      (empty),
		.cmd        (head_cmd),
		.pop        (pop),
		.out_tvalid (out_tvalid),
		.out_tready (out_tready),
		.out_tdata  (out_tdata),
		.out_tlast  (out_tlast)
	);

endmodule

@@ rtl/icte_checker.sv @@
// Port-level checks of the IRC color text encoder, attached by bind.
// Depends only on the top-level ports.
module icte_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_tready,
	input logic        out_tvalid,
	input logic        out_tready,
	input logic [7:0]  out_tdata,
	input logic        out_tlast
);

	// hold a stalled transaction
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
		else $error("output transaction changed while stalled");

	// every emitted byte is 7-bit
	a_seven_bit: assert property (@(posedge clk) disable iff (!arst_n)
		out_tvalid |-> !out_tdata[7])
		else $error("output byte above 0x7f");

	// input backs up only behind pending output
	a_full_pending: assert property (@(posedge clk) disable iff (!arst_n)
		!in_tready |-> out_tvalid)
		else $error("input stalled with no output pending");

endmodule

bind irc_color_text_encoder icte_checker u_icte_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_tready  (in_tready),
	.out_tvalid (out_tvalid),
	.out_tready (out_tready),
	.out_tdata  (out_tdata),
	.out_tlast  (out_tlast)
);
